// File: hw/rtl/positional_array_list_defines.svh
// Assertion macros for the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PAL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional_array_list: check failed");

// next-cycle implication, sampled on clk, off during reset
`define PAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional_array_list: check failed");

`endif

// File: hw/rtl/pal_pkg.sv
// Types, constants and microcode encodings for the positional array list.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

	localparam int DEPTH  = 128;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 8;
	localparam int DATA_W = 32;
	localparam int STEP_W = 4;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_READ   = 2'd3
	} pal_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2
	} pal_status_t;

	typedef struct packed {
		logic [1:0]               command;
		logic [7:0]               position;
		logic signed [DATA_W-1:0] value_in;
	} pal_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [1:0]               status;
		logic [7:0]               count_after;
		logic                     list_empty;
		logic                     list_full;
	} pal_rsp_t;

	typedef enum logic [STEP_W-1:0] {
		S_IDLE    = 4'd0,
		S_DISP    = 4'd1,
		S_INS     = 4'd2,
		S_INS_CHK = 4'd3,
		S_INS_MOV = 4'd4,
		S_INS_PUT = 4'd5,
		S_DEL     = 4'd6,
		S_DEL_CAP = 4'd7,
		S_DEL_CHK = 4'd8,
		S_DEL_MOV = 4'd9,
		S_DEL_END = 4'd10,
		S_RD      = 4'd11,
		S_RD_CAP  = 4'd12,
		S_EMIT    = 4'd13
	} pal_step_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_GOTO,
		C_WAIT_IN,
		C_DISPATCH,
		C_PTR_EQ_POS,
		C_PTR_LAST,
		C_WAIT_OUT
	} pal_cond_t;

	typedef enum logic [1:0] {
		RA_POS,
		RA_PTR_DEC,
		RA_PTR_INC
	} pal_rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_RDATA,
		WR_VAL
	} pal_wr_op_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_CNT,
		PTR_POS,
		PTR_DEC,
		PTR_INC
	} pal_ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} pal_cnt_op_t;

	typedef struct packed {
		pal_cond_t   cond;
		pal_step_t   target;
		pal_rd_sel_t rd_sel;
		pal_wr_op_t  wr_op;
		pal_ptr_op_t ptr_op;
		pal_cnt_op_t cnt_op;
		logic        st_ld;
		logic        res_ld;
		logic        emit;
	} pal_uop_t;

	typedef struct packed {
		logic     err;
		pal_cmd_t cmd;
		logic     ptr_eq_pos;
		logic     ptr_last;
		logic     out_busy;
	} pal_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/pal_rom.sv
// Microcode control store: one control word per sequencer step.
`timescale 1ns / 1ps
`default_nettype none

module pal_rom (
	input  pal_pkg::pal_step_t step,
	output pal_pkg::pal_uop_t  uop
);
	import pal_pkg::*;

	always_comb begin
		uop        = '0;
		uop.cond   = C_NEXT;
		uop.target = S_IDLE;
		uop.rd_sel = RA_POS;
		uop.wr_op  = WR_NONE;
		uop.ptr_op = PTR_HOLD;
		uop.cnt_op = CNT_HOLD;
		unique case (step)
			S_IDLE: begin
				uop.cond   = C_WAIT_IN;
				uop.target = S_IDLE;
			end
			S_DISP: begin
				uop.cond  = C_DISPATCH;
				uop.st_ld = 1'b1;
			end
			S_INS: begin
				uop.ptr_op = PTR_CNT;
			end
			S_INS_CHK: begin
				uop.cond   = C_PTR_EQ_POS;
				uop.target = S_INS_PUT;
				uop.rd_sel = RA_PTR_DEC;
			end
			S_INS_MOV: begin
				uop.cond   = C_GOTO;
				uop.target = S_INS_CHK;
				uop.wr_op  = WR_RDATA;
				uop.ptr_op = PTR_DEC;
			end
			S_INS_PUT: begin
				uop.cond   = C_GOTO;
				uop.target = S_EMIT;
				uop.wr_op  = WR_VAL;
				uop.cnt_op = CNT_INC;
			end
			S_DEL: begin
				uop.rd_sel = RA_POS;
				uop.ptr_op = PTR_POS;
			end
			S_DEL_CAP: begin
				uop.res_ld = 1'b1;
			end
			S_DEL_CHK: begin
				uop.cond   = C_PTR_LAST;
				uop.target = S_DEL_END;
				uop.rd_sel = RA_PTR_INC;
			end
			S_DEL_MOV: begin
				uop.cond   = C_GOTO;
				uop.target = S_DEL_CHK;
				uop.wr_op  = WR_RDATA;
				uop.ptr_op = PTR_INC;
			end
			S_DEL_END: begin
				uop.cond   = C_GOTO;
				uop.target = S_EMIT;
				uop.cnt_op = CNT_DEC;
			end
			S_RD: begin
				uop.rd_sel = RA_POS;
			end
			S_RD_CAP: begin
				uop.cond   = C_GOTO;
				uop.target = S_EMIT;
				uop.res_ld = 1'b1;
			end
			S_EMIT: begin
				uop.cond   = C_WAIT_OUT;
				uop.target = S_IDLE;
				uop.emit   = 1'b1;
			end
			default: begin
				uop.cond   = C_GOTO;
				uop.target = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/pal_seq.sv
// Microcode sequencer: step counter with conditional jumps and command dispatch.
`timescale 1ns / 1ps
`default_nettype none

module pal_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_acc,
	input  pal_pkg::pal_flags_t flags,
	output pal_pkg::pal_uop_t   uop,
	output logic                idle
);
	import pal_pkg::*;

	pal_step_t step_q;
	pal_step_t step_d;
	pal_step_t step_inc;
	pal_step_t disp_target;

	pal_rom u_rom (
		.step (step_q),
		.uop  (uop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		step_inc = pal_step_t'(STEP_W'(step_q) + STEP_W'(1));
		unique case (flags.cmd)
			CMD_INSERT: disp_target = S_INS;
			CMD_APPEND: disp_target = S_INS;
			CMD_DELETE: disp_target = S_DEL;
			CMD_READ:   disp_target = S_RD;
			default:    disp_target = S_EMIT;
		endcase
		if (flags.err) begin
			disp_target = S_EMIT;
		end
		unique case (uop.cond)
			C_NEXT:       step_d = step_inc;
			C_GOTO:       step_d = uop.target;
			C_WAIT_IN:    step_d = in_acc ? step_inc : uop.target;
			C_DISPATCH:   step_d = disp_target;
			C_PTR_EQ_POS: step_d = flags.ptr_eq_pos ? uop.target : step_inc;
			C_PTR_LAST:   step_d = flags.ptr_last ? uop.target : step_inc;
			C_WAIT_OUT:   step_d = flags.out_busy ? step_q : uop.target;
			default:      step_d = S_IDLE;
		endcase
	end

	assign idle = (step_q == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/pal_dp.sv
// Datapath: entry memory, count, pointer, request capture and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_array_list_defines.svh"

module pal_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_acc,
	input  pal_pkg::pal_req_t   req,
	input  pal_pkg::pal_uop_t   uop,
	output pal_pkg::pal_flags_t flags,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output pal_pkg::pal_rsp_t   rsp
);
	import pal_pkg::*;

	logic [DATA_W-1:0]        mem_q [DEPTH];
	logic [DATA_W-1:0]        rd_q;
	logic [ADDR_W-1:0]        rd_addr;

	pal_cmd_t                 cmd_q;
	logic [CNT_W-1:0]         pos_q;
	logic [DATA_W-1:0]        val_q;
	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        ptr_q;
	logic signed [DATA_W-1:0] res_q;
	pal_status_t              status_q;
	pal_status_t              err_code;

	logic                     out_valid_q;
	pal_rsp_t                 out_q;
	logic                     out_busy;
	logic                     out_ld;

	always_comb begin
		err_code = STAT_OK;
		if (cmd_q == CMD_INSERT || cmd_q == CMD_APPEND) begin
			if (count_q >= CNT_W'(DEPTH)) begin
				err_code = STAT_FULL;
			end else if (pos_q > count_q) begin
				err_code = STAT_BADPOS;
			end
		end else if (pos_q >= count_q) begin
			err_code = STAT_BADPOS;
		end
	end

	always_comb begin
		unique case (uop.rd_sel)
			RA_POS:     rd_addr = pos_q[ADDR_W-1:0];
			RA_PTR_DEC: rd_addr = ptr_q - ADDR_W'(1);
			RA_PTR_INC: rd_addr = ptr_q + ADDR_W'(1);
			default:    rd_addr = pos_q[ADDR_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (uop.wr_op)
			WR_RDATA: mem_q[ptr_q] <= rd_q;
			WR_VAL:   mem_q[ptr_q] <= val_q;
			default: begin
			end
		endcase
		rd_q <= mem_q[rd_addr];
	end

	// request capture; append becomes an insert at the current count
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= pal_cmd_t'(req.command);
			pos_q <= (pal_cmd_t'(req.command) == CMD_APPEND) ? count_q : req.position;
			val_q <= req.value_in;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= '0;
		end else if (uop.res_ld) begin
			res_q <= rd_q;
		end
		if (uop.st_ld) begin
			status_q <= err_code;
		end
		unique case (uop.ptr_op)
			PTR_CNT: ptr_q <= count_q[ADDR_W-1:0];
			PTR_POS: ptr_q <= pos_q[ADDR_W-1:0];
			PTR_DEC: ptr_q <= ptr_q - ADDR_W'(1);
			PTR_INC: ptr_q <= ptr_q + ADDR_W'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (uop.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	assign out_busy = out_valid_q && !rsp_ready;
	assign out_ld   = uop.emit && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q.value_out   <= res_q;
			out_q.status      <= status_q;
			out_q.count_after <= count_q;
			out_q.list_empty  <= (count_q == '0);
			out_q.list_full   <= (count_q == CNT_W'(DEPTH));
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign flags.err        = (err_code != STAT_OK);
	assign flags.cmd        = cmd_q;
	assign flags.ptr_eq_pos = (CNT_W'(ptr_q) == pos_q);
	assign flags.ptr_last   = ((CNT_W'(ptr_q) + CNT_W'(1)) >= count_q);
	assign flags.out_busy   = out_busy;

	`PAL_ASSERT_IMPL(a_inc_room, uop.cnt_op == CNT_INC, count_q < CNT_W'(DEPTH))
	`PAL_ASSERT_IMPL(a_dec_nonempty, uop.cnt_op == CNT_DEC, count_q != '0)
	`PAL_ASSERT_IMPL(a_wr_in_list, uop.wr_op != WR_NONE, CNT_W'(ptr_q) <= count_q)
	`PAL_ASSERT_NEXT(a_res_clear, in_acc, res_q == '0)

endmodule

`default_nettype wire

// File: hw/rtl/positional_array_list.sv
// Positional array list top level: sequencer plus datapath.
// Inserts, appends and deletes shift the entries between the position and the end of
// the list; each moved entry takes a check step and a move step on the single-write
// entry memory. Next request is taken the cycle after the response is loaded. Reset
// clears the count and the sequencer; entries are left as they are and need no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  pal_pkg::pal_req_t req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output pal_pkg::pal_rsp_t rsp
);
	import pal_pkg::*;

	pal_uop_t   uop;
	pal_flags_t flags;
	logic       idle;
	logic       in_acc;

	assign req_ready = idle;
	assign in_acc    = req_valid && idle;

	pal_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_acc (in_acc),
		.flags  (flags),
		.uop    (uop),
		.idle   (idle)
	);

	pal_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.req       (req),
		.uop       (uop),
		.flags     (flags),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
